// ===== src/tts_pkg.sv =====
// Package with the shared constants and request types of the terminal text sanitizer.
`default_nettype none
package tts_pkg;

   localparam int unsigned MAX_TAB_WIDTH_DEFAULT = 16;
   localparam int unsigned QUEUE_DEPTH_DEFAULT   = 2;
   localparam int unsigned TAB_W                 = 5;
   localparam logic [TAB_W-1:0] TAB_WIDTH_RESET  = 5'd4;

   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_ESC       = 8'h1B;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CSI_FINAL_LO   = 8'h40;
   localparam logic [7:0] CSI_FINAL_HI   = 8'h7E;
   localparam logic [7:0] PRINTABLE_MIN  = 8'h20;

   typedef enum logic [1:0] {
      BODY_NONE = 2'd0,
      BODY_BYTE = 2'd1,
      BODY_TAB  = 2'd2
   } body_kind_type;

   typedef struct packed {
      logic          lead_lf;
      body_kind_type kind;
      logic [7:0]    data;
      logic          tail_lf;
   } cmd_type;

endpackage
`default_nettype wire

// ===== src/tts_channels.sv =====
// Channel interfaces for the request, result and configuration ports.
`default_nettype none
interface tts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_message;
   modport source (output valid, output in_byte, output end_of_message, input ready);
   modport sink (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface tts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   modport source (output valid, output out_byte, output run_last, input ready);
   modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

interface tts_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] tab_width;
   modport source (output valid, output tab_width, input ready);
   modport sink (input valid, input tab_width, output ready);
endinterface
`default_nettype wire

// ===== src/tts_front.sv =====
// Front end: accepts requests, tracks escape and CR state, and classifies each byte.
`default_nettype none
module tts_front
   import tts_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tts_req_if.sink   req,
   input  wire logic queue_full,
   output cmd_type   cmd,
   output logic      push
);

   logic esc_ff, esc_in;
   logic csi_ff, csi_in;
   logic cr_ff, cr_in;
   logic accept;
   logic [7:0] b;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;

   always_comb begin
      esc_in      = esc_ff;
      csi_in      = csi_ff;
      cr_in       = 1'b0;
      cmd.lead_lf = cr_ff && (b != CHAR_LF);
      cmd.kind    = BODY_NONE;
      cmd.data    = b;
      cmd.tail_lf = 1'b0;
      if (b == CHAR_ESC) begin
         esc_in = 1'b1;
         csi_in = 1'b0;
      end else if (esc_ff) begin
         esc_in = 1'b0;
         csi_in = (b == CHAR_LBRACKET);
      end else if (csi_ff) begin
         if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) begin
            csi_in = 1'b0;
         end
      end else if (b == CHAR_CR) begin
         cr_in = 1'b1;
      end else if (b == CHAR_LF) begin
         cmd.kind = BODY_BYTE;
      end else if (b == CHAR_TAB) begin
         cmd.kind = BODY_TAB;
      end else if (b >= PRINTABLE_MIN) begin
         cmd.kind = BODY_BYTE;
      end
      if (req.end_of_message) begin
         cmd.tail_lf = cr_in;
         cr_in       = 1'b0;
         esc_in      = 1'b0;
         csi_in      = 1'b0;
      end
   end

   assign push = accept && (cmd.lead_lf || (cmd.kind != BODY_NONE) || cmd.tail_lf);

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
         csi_ff <= 1'b0;
         cr_ff  <= 1'b0;
      end else if (accept) begin
         esc_ff <= esc_in;
         csi_ff <= csi_in;
         cr_ff  <= cr_in;
      end
   end

   // A pending CR only arises outside any escape and is resolved by the next byte.
   assert property (@(posedge clock) disable iff (reset) cr_ff |-> !esc_ff && !csi_ff)
      else $error("CR pending while inside an escape");
   assert property (@(posedge clock) disable iff (reset) !(esc_ff && csi_ff))
      else $error("escape and CSI state both set");
   assert property (@(posedge clock) disable iff (reset)
      accept && req.end_of_message |=> !esc_ff && !csi_ff && !cr_ff)
      else $error("state not cleared at message end");

endmodule
`default_nettype wire

// ===== src/tts_queue.sv =====
// Short request queue between the front end and the back end.
`default_nettype none
module tts_queue
   import tts_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         head_valid,
   output logic         full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("request pushed into a full queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ===== src/tts_back.sv =====
// Back end: holds the tab width and expands each queued request into result bytes.
`default_nettype none
module tts_back
   import tts_pkg::*;
#(
   parameter int unsigned MAX_TAB_WIDTH = MAX_TAB_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   tts_csr_if.sink      csr,
   tts_rsp_if.source    rsp,
   input  wire cmd_type head,
   input  wire logic    head_valid,
   output logic         pop
);

   localparam int unsigned IDX_W = $clog2(MAX_TAB_WIDTH + 3);
   localparam int unsigned CMP_W = (IDX_W > TAB_W) ? IDX_W : TAB_W;

   logic [TAB_W-1:0] tab_width_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0] tab_ext, tab_clamped;
   logic [IDX_W-1:0] body_total, total, body_pos;
   logic [7:0]       body_byte;
   logic             emit;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_width_ff <= TAB_WIDTH_RESET;
      end else if (csr.valid) begin
         tab_width_ff <= csr.tab_width;
      end
   end

   always_comb begin
      tab_ext = CMP_W'(tab_width_ff);
      if (tab_ext == '0) begin
         tab_clamped = CMP_W'(1);
      end else if (tab_ext > CMP_W'(MAX_TAB_WIDTH)) begin
         tab_clamped = CMP_W'(MAX_TAB_WIDTH);
      end else begin
         tab_clamped = tab_ext;
      end
   end

   always_comb begin
      unique case (head.kind)
         BODY_BYTE: begin
            body_total = IDX_W'(1);
            body_byte  = head.data;
         end
         BODY_TAB: begin
            body_total = IDX_W'(tab_clamped);
            body_byte  = CHAR_SPACE;
         end
         default: begin
            body_total = '0;
            body_byte  = head.data;
         end
      endcase
   end

   assign total    = IDX_W'(head.lead_lf) + body_total + IDX_W'(head.tail_lf);
   assign body_pos = idx_ff - IDX_W'(head.lead_lf);
   assign emit     = head_valid && (!rsp_valid_ff || rsp.ready);
   assign pop      = emit && (idx_ff + 1'b1 == total);

   always_comb begin
      if (head.lead_lf && idx_ff == '0) begin
         rsp_byte_in = CHAR_LF;
      end else if (body_pos < body_total) begin
         rsp_byte_in = body_byte;
      end else begin
         rsp_byte_in = CHAR_LF;
      end
      rsp_last_in  = (idx_ff + 1'b1 == total);
      rsp_valid_in = emit || (rsp_valid_ff && !rsp.ready);
      if (pop) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.run_last = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset) head_valid |-> idx_ff < total)
      else $error("expansion index beyond request length");
   assert property (@(posedge clock) disable iff (reset) !head_valid |-> idx_ff == '0)
      else $error("expansion index left over with no request queued");
   assert property (@(posedge clock) disable iff (reset)
      emit && !pop |=> rsp_valid_ff && !rsp_last_ff)
      else $error("run_last set before the request is finished");

endmodule
`default_nettype wire

// ===== src/terminal_text_sanitizer.sv =====
// Top level of the terminal text sanitizer: front end, request queue and back end.
//
//   Channel  Dir  Payload                       Transfer
//   req_if   in   in_byte[7:0], end_of_message  valid && ready
//   rsp_if   out  out_byte[7:0], run_last       valid && ready
//   csr_if   in   tab_width[4:0]                valid && ready (ready is always high)
//
// A request that yields one byte passes through a queue entry and then the result
// register to rsp_if; one request per cycle is sustained while each yields one byte
// and rsp_if.ready stays high. A tab expands into the clamped tab width in spaces,
// after a line feed for a resolved CR; requests that yield nothing are not queued.
// The queue (two entries by default) lets the front end keep taking requests while the back
// end expands a tab or waits on rsp_if.ready; the result register holds still.
// Synchronous reset clears escape and CR state, the queue and the result valid flag, and sets the tab width to 4.
`default_nettype none
module terminal_text_sanitizer
   import tts_pkg::*;
#(
   parameter int unsigned MAX_TAB_WIDTH = MAX_TAB_WIDTH_DEFAULT,
   parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   tts_req_if.sink   req_if,
   tts_rsp_if.source rsp_if,
   tts_csr_if.sink   csr_if
);

   cmd_type front_cmd;
   cmd_type head;
   logic    push;
   logic    pop;
   logic    head_valid;
   logic    queue_full;

   tts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .queue_full (queue_full),
      .cmd        (front_cmd),
      .push       (push)
   );

   tts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   tts_back #(
      .MAX_TAB_WIDTH (MAX_TAB_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_if),
      .rsp        (rsp_if),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

endmodule
`default_nettype wire

// ===== tb/sv/terminal_text_sanitizer_tb.sv =====
// Self-checking testbench for the terminal text sanitizer, with a scoreboard that predicts cleaned bytes.
`default_nettype none

class clean_text_board;
   typedef struct {
      logic [7:0] ch;
      logic       tail;
   } clean_byte_type;

   clean_byte_type pending_clean[$];
   logic [4:0]  tab_width = tts_pkg::TAB_WIDTH_RESET;
   bit          escape_seen = 0;
   bit          in_csi = 0;
   bit          cr_held = 0;
   int unsigned mismatches = 0;
   int unsigned requests = 0;
   int unsigned results = 0;
   int unsigned tabs = 0;

   task report(input string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   function void set_tab_width(input logic [4:0] w);
      tab_width = w;
   endfunction

   function void note_raw_byte(input logic [7:0] b, input logic eom);
      clean_byte_type run[$];
      clean_byte_type item;
      int unsigned spaces;
      requests++;
      item.tail = 1'b0;
      if (cr_held) begin
         cr_held = 0;
         if (b != tts_pkg::CHAR_LF) begin
            item.ch = tts_pkg::CHAR_LF;
            run.push_back(item);
         end
      end
      if (b == tts_pkg::CHAR_ESC) begin
         escape_seen = 1;
         in_csi = 0;
      end else if (escape_seen) begin
         escape_seen = 0;
         in_csi = (b == tts_pkg::CHAR_LBRACKET);
      end else if (in_csi) begin
         if (b >= tts_pkg::CSI_FINAL_LO && b <= tts_pkg::CSI_FINAL_HI) in_csi = 0;
      end else if (b == tts_pkg::CHAR_CR) begin
         cr_held = 1;
      end else if (b == tts_pkg::CHAR_LF) begin
         item.ch = tts_pkg::CHAR_LF;
         run.push_back(item);
      end else if (b == tts_pkg::CHAR_TAB) begin
         tabs++;
         spaces = {27'd0, tab_width};
         if (spaces < 1) spaces = 1;
         if (spaces > tts_pkg::MAX_TAB_WIDTH_DEFAULT) spaces = tts_pkg::MAX_TAB_WIDTH_DEFAULT;
         item.ch = tts_pkg::CHAR_SPACE;
         repeat (spaces) run.push_back(item);
      end else if (b >= tts_pkg::PRINTABLE_MIN) begin
         item.ch = b;
         run.push_back(item);
      end
      if (eom) begin
         if (cr_held) begin
            item.ch = tts_pkg::CHAR_LF;
            run.push_back(item);
         end
         cr_held = 0;
         escape_seen = 0;
         in_csi = 0;
      end
      if (run.size() > 0) run[run.size() - 1].tail = 1'b1;
      foreach (run[i]) pending_clean.push_back(run[i]);
   endfunction

   task check_clean_byte(input logic [7:0] b, input logic tail);
      clean_byte_type want;
      results++;
      if (pending_clean.size() == 0) begin
         report($sformatf("result %0d: byte %h with none expected", results, b));
      end else begin
         want = pending_clean.pop_front();
         if (b !== want.ch)
            report($sformatf("result %0d: out_byte %h, expected %h", results, b, want.ch));
         if (tail !== want.tail)
            report($sformatf("result %0d: run_last %b, expected %b", results, tail, want.tail));
      end
   endtask
endclass

module terminal_text_sanitizer_tb;
   import tts_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_PER_PHASE = 11;
   localparam logic [8:0] DIRECTED [0:26] = '{
      {1'b0, 8'h41}, {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, CHAR_TAB},
      {1'b0, CHAR_CR}, {1'b0, CHAR_LF}, {1'b0, CHAR_CR}, {1'b0, 8'h78},
      {1'b0, CHAR_ESC}, {1'b0, CHAR_LBRACKET}, {1'b0, 8'h07}, {1'b0, CSI_FINAL_HI},
      {1'b0, CHAR_ESC}, {1'b0, 8'h63}, {1'b0, CHAR_ESC}, {1'b0, CHAR_LBRACKET},
      {1'b0, CHAR_ESC}, {1'b0, 8'h5A}, {1'b1, CHAR_CR}, {1'b1, CHAR_ESC},
      {1'b0, CHAR_LBRACKET}, {1'b0, CHAR_ESC}, {1'b0, CHAR_LBRACKET}, {1'b0, CSI_FINAL_LO},
      {1'b0, 8'h1F}, {1'b0, CHAR_CR}, {1'b1, CHAR_TAB}
   };
   localparam logic [4:0] PHASE_WIDTHS [0:4] = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17};

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit quiet = 0;
   int unsigned cycles = 0;
   int unsigned raw_sent = 0;
   int unsigned phase_start;

   tts_req_if req_if ();
   tts_rsp_if rsp_if ();
   tts_csr_if csr_if ();

   clean_text_board board = new;

   terminal_text_sanitizer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.in_byte = 8'h00;
      req_if.end_of_message = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.tab_width = 5'd0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles.", cycles);
         $display("** terminal_text_sanitizer: FAILED **");
         $finish;
      end
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) board.set_tab_width(csr_if.tab_width);
         if (req_if.valid && req_if.ready)
            board.note_raw_byte(req_if.in_byte, req_if.end_of_message);
         if (rsp_if.valid && rsp_if.ready) board.check_clean_byte(rsp_if.out_byte, rsp_if.run_last);
      end
   end

   task send_raw(input logic [7:0] b, input logic eom);
      while (!quiet && $urandom_range(99) < 16) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.end_of_message <= eom;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      raw_sent++;
      @(negedge clock);
   endtask

   task send_random(input logic [7:0] b);
      send_raw(b, $urandom_range(11) == 0);
   endtask

   task send_random_token;
      int unsigned params;
      case ($urandom_range(9)) inside
         [0:3]: send_random(8'($urandom_range(255, 32)));
         4: begin
            send_random(CHAR_CR);
            if ($urandom_range(1)) send_random(CHAR_LF);
         end
         5: send_random(CHAR_LF);
         6: send_random(CHAR_TAB);
         7: begin
            send_random(CHAR_ESC);
            send_random(CHAR_LBRACKET);
            params = $urandom_range(3);
            repeat (params) begin
               if ($urandom_range(4) == 0) send_random(8'($urandom_range(255)));
               else send_random(8'($urandom_range(63, 32)));
            end
            send_random(8'($urandom_range(CSI_FINAL_HI, CSI_FINAL_LO)));
         end
         8: begin
            send_random(CHAR_ESC);
            send_random(8'($urandom_range(255)));
         end
         default: send_random(8'($urandom_range(255)));
      endcase
   endtask

   task settle;
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (board.pending_clean.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task write_tab_width(input logic [4:0] w);
      csr_if.valid <= 1'b1;
      csr_if.tab_width <= w;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task run_random_phase(input logic [4:0] w);
      write_tab_width(w);
      phase_start = raw_sent;
      while (raw_sent - phase_start < RANDOM_PER_PHASE) send_random_token();
      settle();
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_raw(DIRECTED[i][7:0], DIRECTED[i][8]);
      settle();

      foreach (PHASE_WIDTHS[i]) begin
         quiet = (PHASE_WIDTHS[i] == 5'd16);
         run_random_phase(PHASE_WIDTHS[i]);
      end
      quiet = 0;
      run_random_phase(5'($urandom_range(31)));

      repeat (16) @(negedge clock);
      if (board.pending_clean.size() != 0)
         board.report($sformatf("%0d cleaned bytes never arrived", board.pending_clean.size()));

      $display("Sent %0d requests (%0d tabs) and checked %0d cleaned bytes in %0d cycles.",
               board.requests, board.tabs, board.results, cycles);
      $display("Tab widths 4, 0, 16, 31, 1, 17 and one random were used; %0d mismatches.",
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("** terminal_text_sanitizer: PASSED **");
      end else begin
         $display("** terminal_text_sanitizer: FAILED **");
      end
      $finish;
   end
endmodule

`default_nettype wire
